// ===== hw/rtl/pprc_pkg.sv =====
// Package for the partial permutation rank codec.
// Holds widths, register codes, the pipeline item type and the constant tables.
// No dependencies.
package pprc_pkg;

  localparam int unsigned MaxPiecesDef = 6;   // default for MAX_PIECES
  localparam int unsigned NumPieceFld  = 6;   // piece fields on the ports
  localparam int unsigned PieceW       = 5;
  localparam int unsigned CoordW       = 26;
  localparam int unsigned PosW         = 4;
  localparam int unsigned OriW         = 2;
  localparam int unsigned RemW         = 5;
  localparam int unsigned SlotMax      = 12;
  localparam int unsigned CntW         = 3;
  localparam int unsigned RecipShift   = 28;
  localparam int unsigned NumCodes     = 24;  // legal piece codes 0..23
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 3;

  localparam logic [CfgIdxW-1:0] CfgCornerMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPieceCount = 2'd1;

  typedef struct packed {
    logic                                 op;
    logic                                 corner;
    logic [CntW-1:0]                      cnt;
    logic                                 bad;
    logic [CoordW-1:0]                    x;      // unrank: remaining quotient
    logic [CoordW-1:0]                    acc;    // rank: Horner accumulator
    logic [NumPieceFld-1:0][PosW-1:0]     pdig;   // rank permutation digits
    logic [NumPieceFld-1:0][OriW-1:0]     rori;   // rank orientations
    logic [NumPieceFld-1:0][OriW-1:0]     uori;   // unrank orientations
    logic [NumPieceFld-1:0][PosW-1:0]     upos;   // unrank positions
    logic [SlotMax-1:0]                   used;
  } pprc_item_t;

  function automatic logic [PosW-1:0] pprc_slots(logic corner);
    return corner ? PosW'(8) : PosW'(12);
  endfunction

  function automatic logic [OriW-1:0] pprc_radix(logic corner);
    return corner ? OriW'(3) : OriW'(2);
  endfunction

  // floor(2^RecipShift / d); quotient estimate is exact or one low
  function automatic logic [RecipShift-1:0] pprc_recip(logic [PosW-1:0] d);
    logic [RecipShift-1:0] r;
    unique case (d)
      4'd2:    r = 28'd134217728;
      4'd3:    r = 28'd89478485;
      4'd4:    r = 28'd67108864;
      4'd5:    r = 28'd53687091;
      4'd6:    r = 28'd44739242;
      4'd7:    r = 28'd38347922;
      4'd8:    r = 28'd33554432;
      4'd9:    r = 28'd29826161;
      4'd10:   r = 28'd26843545;
      4'd11:   r = 28'd24403223;
      4'd12:   r = 28'd22369621;
      default: r = '0;
    endcase
    return r;
  endfunction

  // number of coordinates for a mode and piece count
  function automatic logic [CoordW-1:0] pprc_total(logic corner, logic [CntW-1:0] cnt);
    logic [CoordW-1:0] t;
    if (corner) begin
      unique case (cnt)
        3'd1:    t = 26'd24;
        3'd2:    t = 26'd504;
        3'd3:    t = 26'd9072;
        3'd4:    t = 26'd136080;
        3'd5:    t = 26'd1632960;
        3'd6:    t = 26'd14696640;
        default: t = '0;
      endcase
    end else begin
      unique case (cnt)
        3'd1:    t = 26'd24;
        3'd2:    t = 26'd528;
        3'd3:    t = 26'd10560;
        3'd4:    t = 26'd190080;
        3'd5:    t = 26'd3041280;
        3'd6:    t = 26'd42577920;
        default: t = '0;
      endcase
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/pprc_prep.sv =====
// First pipeline stage: piece decode, range and duplicate checks, permutation digits.
// Depends on pprc_pkg.
module pprc_prep (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            valid_i,
  input  logic                                            op_i,
  input  logic                                            corner_i,
  input  logic [pprc_pkg::CntW-1:0]                       cnt_i,
  input  logic [pprc_pkg::NumPieceFld-1:0][pprc_pkg::PieceW-1:0] piece_i,
  input  logic [pprc_pkg::CoordW-1:0]                     coord_i,
  output logic                                            valid_o,
  output pprc_pkg::pprc_item_t                            item_o
);
  import pprc_pkg::*;

  logic                 valid_q;
  pprc_item_t           item_q, item_d;

  always_comb begin
    logic [NumPieceFld-1:0][PosW-1:0] pos;
    logic [PosW-1:0]                  sl;
    logic [OriW-1:0]                  rd;
    logic [8:0]                       p11;
    logic [PieceW-1:0]                orem;
    logic [CntW-1:0]                  nlow;
    logic                             bad;
    sl  = pprc_slots(corner_i);
    rd  = pprc_radix(corner_i);
    bad = 1'b0;
    item_d        = '0;
    item_d.op     = op_i;
    item_d.corner = corner_i;
    item_d.cnt    = cnt_i;
    item_d.x      = coord_i;
    for (int i = 0; i < NumPieceFld; i++) begin
      // piece/3 as (piece*11)>>5, exact for 5-bit values
      p11    = 9'(piece_i[i]) * 9'd11;
      pos[i] = corner_i ? p11[8:5] : piece_i[i][PieceW-1:1];
      orem   = piece_i[i] - PieceW'(pos[i]) * PieceW'(rd);
      item_d.rori[i] = orem[OriW-1:0];
    end
    for (int i = 0; i < NumPieceFld; i++) begin
      nlow = '0;
      for (int j = 0; j < i; j++) begin
        if (pos[j] < pos[i]) nlow = nlow + CntW'(1);
        if (CntW'(i) < cnt_i && pos[j] == pos[i]) bad = 1'b1;
      end
      if (CntW'(i) < cnt_i && pos[i] >= sl) bad = 1'b1;
      item_d.pdig[i] = pos[i] - PosW'(nlow);
    end
    item_d.bad = op_i ? (coord_i >= pprc_total(corner_i, cnt_i)) : bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/pprc_step.sv =====
// One digit step over two register stages: reciprocal multiply, then remainder
// correction and slot select for unranking; one Horner step for ranking.
// Depends on pprc_pkg.
module pprc_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      phase_i,  // 0 orientation/perm-Horner, 1 perm/orientation
  input  logic [pprc_pkg::CntW-1:0] k_i,
  input  logic                      valid_i,
  input  pprc_pkg::pprc_item_t      item_i,
  output logic                      valid_o,
  output pprc_pkg::pprc_item_t      item_o
);
  import pprc_pkg::*;

  logic                           mid_valid_q, out_valid_q;
  pprc_item_t                     mid_q, mid_d, out_q, out_d;
  logic [CoordW-1:0]              q0_q, q0_d;
  logic [PosW-1:0]                div_q, div_a;

  // stage A
  always_comb begin
    logic                            active;
    logic [CntW-1:0]                 idx;
    logic [PosW-1:0]                 sl;
    logic [OriW-1:0]                 rd;
    logic [CoordW+RecipShift-1:0]    prod;
    logic [CoordW-1:0]               mult;
    sl     = pprc_slots(item_i.corner);
    rd     = pprc_radix(item_i.corner);
    active = k_i < item_i.cnt;
    idx    = phase_i ? k_i : item_i.cnt - k_i - CntW'(1);
    div_a  = phase_i ? sl - PosW'(k_i) : PosW'(rd);
    prod   = (CoordW+RecipShift)'(item_i.x) * (CoordW+RecipShift)'(pprc_recip(div_a));
    q0_d   = prod[CoordW+RecipShift-1:RecipShift];
    mid_d  = item_i;
    mult   = '0;
    if (active) begin
      if (!phase_i) begin
        mult      = item_i.acc * CoordW'(sl - PosW'(idx));
        mid_d.acc = mult + CoordW'(item_i.pdig[idx]);
      end else begin
        mult      = item_i.acc * CoordW'(rd);
        mid_d.acc = mult + CoordW'(item_i.rori[idx]);
      end
    end
  end

  // stage B
  always_comb begin
    logic                 active;
    logic [CntW-1:0]      idx;
    logic [PosW-1:0]      sl;
    logic [CoordW-1:0]    rfull;
    logic [RemW-1:0]      rem;
    logic [CoordW-1:0]    q;
    logic [SlotMax-1:0]   free;
    logic [SlotMax-1:0]   lowmask;
    logic [PosW-1:0]      pos;
    sl     = pprc_slots(mid_q.corner);
    active = k_i < mid_q.cnt;
    idx    = phase_i ? k_i : mid_q.cnt - k_i - CntW'(1);
    rfull  = mid_q.x - q0_q * CoordW'(div_q);
    rem    = rfull[RemW-1:0];
    q      = q0_q;
    if (rem >= RemW'(div_q)) begin
      q   = q0_q + CoordW'(1);
      rem = rem - RemW'(div_q);
    end
    free = ~mid_q.used & ((SlotMax'(1) << sl) - SlotMax'(1));
    pos  = sl - PosW'(1);
    // digit d selects the d-th free slot in ascending order
    for (int s = 0; s < SlotMax; s++) begin
      lowmask = (SlotMax'(1) << s) - SlotMax'(1);
      if (free[s] && PosW'($countones(free & lowmask)) == rem[PosW-1:0]) pos = PosW'(s);
    end
    out_d = mid_q;
    if (active) begin
      out_d.x = q;
      if (!phase_i) begin
        out_d.uori[idx] = rem[OriW-1:0];
      end else begin
        out_d.upos[idx] = pos;
        out_d.used[pos] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      mid_valid_q <= valid_i;
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
      q0_q  <= q0_d;
      div_q <= div_a;
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

// ===== hw/rtl/partial_permutation_rank_codec.sv =====
// Partial permutation rank codec: ranks up to six pieces (radix*position+orientation)
// into one coordinate, or unranks a coordinate back into pieces, in edge or corner mode.
// Depends on pprc_pkg, pprc_prep and pprc_step.
//
// Fully pipelined, one transaction per cycle in each direction unless the output
// stalls. From input acceptance to result valid there is one decode stage, then
// one two-stage digit step per orientation digit and per permutation digit, each
// step built around one reciprocal multiplier, then the output register. The whole
// pipeline holds while a result waits at the output; in_ready_o follows that.
// Configuration writes are always taken and must only be issued while the pipeline
// is empty.
module partial_permutation_rank_codec #(
  parameter int unsigned MAX_PIECES = pprc_pkg::MaxPiecesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pprc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pprc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [pprc_pkg::PieceW-1:0]     piece_in_0_i,
  input  logic [pprc_pkg::PieceW-1:0]     piece_in_1_i,
  input  logic [pprc_pkg::PieceW-1:0]     piece_in_2_i,
  input  logic [pprc_pkg::PieceW-1:0]     piece_in_3_i,
  input  logic [pprc_pkg::PieceW-1:0]     piece_in_4_i,
  input  logic [pprc_pkg::PieceW-1:0]     piece_in_5_i,
  input  logic [pprc_pkg::CoordW-1:0]     coordinate_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pprc_pkg::PieceW-1:0]     piece_out_0_o,
  output logic [pprc_pkg::PieceW-1:0]     piece_out_1_o,
  output logic [pprc_pkg::PieceW-1:0]     piece_out_2_o,
  output logic [pprc_pkg::PieceW-1:0]     piece_out_3_o,
  output logic [pprc_pkg::PieceW-1:0]     piece_out_4_o,
  output logic [pprc_pkg::PieceW-1:0]     piece_out_5_o,
  output logic [pprc_pkg::CoordW-1:0]     coordinate_out_o,
  output logic                            bad_input_o
);
  import pprc_pkg::*;

  localparam int unsigned NumSteps = 2 * MAX_PIECES;

  logic                   corner_q;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        cnt_eff;
  logic                   en;

  logic [NumSteps:0]      vchain;
  pprc_item_t             ichain [NumSteps+1];

  logic [NumPieceFld-1:0][PieceW-1:0] pin;
  logic [NumPieceFld-1:0][PieceW-1:0] pout_d, pout_q;
  logic [CoordW-1:0]      coord_d, coord_q;
  logic                   bad_q, out_valid_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= 1'b0;
      count_q  <= CntW'(4);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCornerMode: corner_q <= cfg_data_i[0];
        CfgPieceCount: count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_eff = count_q;
    if (count_q == '0) cnt_eff = CntW'(1);
    else if (count_q > CntW'(MAX_PIECES)) cnt_eff = CntW'(MAX_PIECES);
  end

  // global stall: every stage holds while the output register is full and not taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign pin = {piece_in_5_i, piece_in_4_i, piece_in_3_i,
                piece_in_2_i, piece_in_1_i, piece_in_0_i};

  pprc_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .op_i     (opcode_i),
    .corner_i (corner_q),
    .cnt_i    (cnt_eff),
    .piece_i  (pin),
    .coord_i  (coordinate_in_i),
    .valid_o  (vchain[0]),
    .item_o   (ichain[0])
  );

  for (genvar g = 0; g < NumSteps; g++) begin : g_step
    localparam int unsigned StepK = (g < MAX_PIECES) ? g : g - MAX_PIECES;
    pprc_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .phase_i (g >= MAX_PIECES),
      .k_i     (CntW'(StepK)),
      .valid_i (vchain[g]),
      .item_i  (ichain[g]),
      .valid_o (vchain[g+1]),
      .item_o  (ichain[g+1])
    );
  end

  always_comb begin
    pprc_item_t      fin;
    logic [OriW-1:0] rd;
    fin = ichain[NumSteps];
    rd  = pprc_radix(fin.corner);
    for (int i = 0; i < NumPieceFld; i++) begin
      pout_d[i] = '0;
      if (fin.op && !fin.bad && CntW'(i) < fin.cnt) begin
        pout_d[i] = PieceW'(fin.upos[i]) * PieceW'(rd) + PieceW'(fin.uori[i]);
      end
    end
    coord_d = (!fin.op && !fin.bad) ? fin.acc : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vchain[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pout_q  <= pout_d;
      coord_q <= coord_d;
      bad_q   <= ichain[NumSteps].bad;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign piece_out_0_o    = pout_q[0];
  assign piece_out_1_o    = pout_q[1];
  assign piece_out_2_o    = pout_q[2];
  assign piece_out_3_o    = pout_q[3];
  assign piece_out_4_o    = pout_q[4];
  assign piece_out_5_o    = pout_q[5];
  assign coordinate_out_o = coord_q;
  assign bad_input_o      = bad_q;

  a_rank_no_pieces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coordinate_out_o != '0 |->
      piece_out_0_o == '0 && piece_out_1_o == '0 && piece_out_2_o == '0 &&
      piece_out_3_o == '0 && piece_out_4_o == '0 && piece_out_5_o == '0)
    else $error("ranked result carries unranked pieces");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_input_o |-> coordinate_out_o == '0 && piece_out_0_o == '0)
    else $error("invalid transaction produced nonzero result");

  a_piece_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> piece_out_0_o < PieceW'(NumCodes) && piece_out_5_o < PieceW'(NumCodes))
    else $error("unranked piece out of range");

endmodule
